// ----- design/assert_macros.svh -----
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- design/kceq_pkg.sv -----
// types and constants of the key change event queue
`timescale 1ns / 1ps

package kceq_pkg;

	localparam int unsigned KEY_COUNT = 6;
	localparam int unsigned KEY_W     = 3;
	localparam int unsigned CODE_W    = 4;

	// input item kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	typedef logic [CODE_W-1:0] code_t;

endpackage

// ----- design/kceq_ring.sv -----
// event ring storage: one write port, one registered read port
`timescale 1ns / 1ps

module kceq_ring #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned PTR_W = 3
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [PTR_W-1:0]    wr_addr,
	input  kceq_pkg::code_t     wr_data,
	input  logic [PTR_W-1:0]    rd_addr,
	output kceq_pkg::code_t     rd_data
);
	import kceq_pkg::*;

	code_t mem [DEPTH];
	code_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/key_change_event_queue.sv -----
// key change event queue top level: sequencer, slot pointers and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake            payload
// input     in         in_valid / in_ready  kind, key_lines
// result    out        out_valid / out_ready empty_res, key_index, released
//
// key sample: the transfer, then all six keys walked in order through the one shared
//   slot step and full compare
// read: the transfer, then the registered ring read, plus any wait for the result
//   register to drain; clear and unused kinds end with the transfer
// reset clears pointers, previous sample and control; ring contents stay undefined,
//   there is no clearing pass
// a waiting result holds a read, and with it all input, until the result drains

module key_change_event_queue #(
	parameter int unsigned RING_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [5:0] key_lines,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       empty_res,
	output logic [2:0] key_index,
	output logic       released
);
	import kceq_pkg::*;

	localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
	localparam logic [KEY_W-1:0] LAST_KEY  = KEY_W'(KEY_COUNT - 1);

	state_t state_q, state_d;

	logic [KEY_COUNT-1:0] prev_q;     // last key sample
	logic [KEY_COUNT-1:0] keys_q;     // sample under scan
	logic [KEY_COUNT-1:0] chg_q;      // keys that changed
	logic [KEY_W-1:0]     k_q;        // key being scanned
	logic [PTR_W-1:0]     wr_q;
	logic [PTR_W-1:0]     rd_q;
	logic                 empty_q;    // read found ring empty

	logic                 out_valid_q;
	logic                 empty_res_q;
	logic [KEY_W-1:0]     key_index_q;
	logic                 released_q;

	// shared slot step: write pointer while scanning, read pointer otherwise
	logic [PTR_W-1:0] step_src;
	logic [PTR_W-1:0] step_nxt;
	logic             step_hits_rd;

	logic  take;
	logic  push;
	logic  out_load;
	code_t wr_code;
	code_t rd_code;

	assign step_src     = (state_q == ST_SCAN) ? wr_q : rd_q;
	assign step_nxt     = (step_src == LAST_SLOT) ? '0 : step_src + PTR_W'(1);
	assign step_hits_rd = (step_nxt == rd_q);

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	// release flag in the top bit, key index below
	assign wr_code = {~keys_q[k_q], k_q};

	// sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		push     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (kind)
						KIND_SAMPLE: state_d = ST_SCAN;
						KIND_READ:   state_d = ST_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				// changed key pushes unless the ring is full, then it is dropped
				push = chg_q[k_q] && !step_hits_rd;
				if (k_q == LAST_KEY) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// pointers, sample and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			k_q     <= '0;
			empty_q <= 1'b0;
		end else begin
			if (take) begin
				case (kind)
					KIND_SAMPLE: begin
						prev_q <= key_lines;
						k_q    <= '0;
					end
					KIND_READ: begin
						empty_q <= (wr_q == rd_q);
					end
					KIND_CLEAR: begin
						wr_q <= '0;
						rd_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_SCAN) begin
				k_q <= k_q + KEY_W'(1);
			end
			if (push) begin
				wr_q <= step_nxt;
			end
			if (out_load && !empty_q) begin
				rd_q <= step_nxt;
			end
		end
	end

	// scan payload, no reset needed
	always_ff @(posedge clk) begin
		if (take && kind == KIND_SAMPLE) begin
			keys_q <= key_lines;
			chg_q  <= key_lines ^ prev_q;
		end
	end

	kceq_ring #(
		.DEPTH (RING_DEPTH),
		.PTR_W (PTR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (wr_q),
		.wr_data (wr_code),
		.rd_addr (rd_q),
		.rd_data (rd_code)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			empty_res_q <= empty_q;
			key_index_q <= empty_q ? '0 : rd_code[KEY_W-1:0];
			released_q  <= empty_q ? 1'b0 : rd_code[CODE_W-1];
		end
	end

	assign out_valid = out_valid_q;
	assign empty_res = empty_res_q;
	assign key_index = key_index_q;
	assign released  = released_q;

	// a push always leaves at least one event waiting
	`ASSERT_NEXT(a_push_not_empty, push, wr_q != rd_q, "ring empty after a push")
	// an empty report carries no event
	`ASSERT_SAME(a_empty_clean, out_valid_q && empty_res_q,
		key_index_q == '0 && !released_q, "empty result carries event bits")
	// the scan counter stays inside the key set
	`ASSERT_SAME(a_scan_range, state_q == ST_SCAN, k_q <= LAST_KEY, "scan past last key")
	// loading a result makes it visible next cycle
	`ASSERT_NEXT(a_load_shows, out_load, out_valid_q, "loaded result not valid")

endmodule

// ----- test/tb_top.sv -----
// testbench for the key change event queue: random and directed traffic against a scoreboard
`timescale 1ns / 1ps

import kceq_pkg::*;

// kind 3 has no meaning in the block and must be ignored
localparam logic [1:0] KIND_UNUSED = 2'd3;

typedef struct packed {
	logic       empty;
	logic [2:0] key;
	logic       rel;
} read_result_t;

// predicts the event ring and holds the read results still to come out
class event_queue_scoreboard;
	localparam int DEPTH = 8;

	logic [5:0]   prev_keys;
	int           wr_slot;
	int           rd_slot;
	code_t        ring [DEPTH];
	read_result_t pending_reads [$];
	int errors, checked, samples, reads, clears, pushes, drops, empties;

	function new();
		prev_keys = '0;
		wr_slot   = 0;
		rd_slot   = 0;
		errors    = 0;
		checked   = 0;
		samples   = 0;
		reads     = 0;
		clears    = 0;
		pushes    = 0;
		drops     = 0;
		empties   = 0;
	endfunction

	function int slot_after(int s);
		return (s + 1 == DEPTH) ? 0 : s + 1;
	endfunction

	function void note_input(logic [1:0] k, logic [5:0] keys);
		logic [5:0]   changed;
		code_t        c;
		read_result_t r;
		case (k)
			KIND_SAMPLE: begin
				samples++;
				changed = keys ^ prev_keys;
				for (int i = 0; i < KEY_COUNT; i++) begin
					if (changed[i]) begin
						c      = code_t'(i);
						c[3]   = !keys[i];
						if (slot_after(wr_slot) == rd_slot) begin
							drops++;
						end else begin
							ring[wr_slot] = c;
							wr_slot       = slot_after(wr_slot);
							pushes++;
						end
					end
				end
				prev_keys = keys;
			end
			KIND_READ: begin
				reads++;
				if (wr_slot == rd_slot) begin
					r = '{empty: 1'b1, key: 3'd0, rel: 1'b0};
					empties++;
				end else begin
					c       = ring[rd_slot];
					rd_slot = slot_after(rd_slot);
					r       = '{empty: 1'b0, key: c[2:0], rel: c[3]};
				end
				pending_reads.push_back(r);
			end
			KIND_CLEAR: begin
				clears++;
				wr_slot = 0;
				rd_slot = 0;
			end
			default: ;
		endcase
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(logic e, logic [2:0] ki, logic r);
		read_result_t want;
		if (pending_reads.size() == 0) begin
			report($sformatf("read result with nothing pending (empty %b key %0d rel %b)",
				e, ki, r));
			return;
		end
		want = pending_reads.pop_front();
		checked++;
		if (e !== want.empty)
			report($sformatf("read %0d: empty_res %b, want %b", checked, e, want.empty));
		if (ki !== want.key)
			report($sformatf("read %0d: key_index %0d, want %0d", checked, ki, want.key));
		if (r !== want.rel)
			report($sformatf("read %0d: released %b, want %b", checked, r, want.rel));
	endtask
endclass

module tb_top;

	localparam int RING_DEPTH   = 8;
	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_ITEMS  = 80;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int LIMIT        = 200000;

	// traffic mixes for the random part
	localparam int MIX_BALANCED = 0;
	localparam int MIX_FILL     = 1;
	localparam int MIX_DRAIN    = 2;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [1:0] kind      = KIND_SAMPLE;
	logic [5:0] key_lines = '0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       empty_res;
	logic [2:0] key_index;
	logic       released;

	event_queue_scoreboard sb;

	// no_idle switches off gaps on both sides; long_hold_req asks the receiver for a long stall
	bit no_idle       = 1'b0;
	bit long_hold_req = 1'b0;
	int items_sent    = 0;
	int cycles        = 0;

	key_change_event_queue #(
		.RING_DEPTH(RING_DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.key_lines (key_lines),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.empty_res (empty_res),
		.key_index (key_index),
		.released  (released)
	);

	always #1 clk = ~clk;

	// watchdog, also stops a run that never drains
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one input transfer, with an optional idle burst in front of it;
	// returns on the edge at which the transfer happened, valid still high
	task automatic send_item(input logic [1:0] k, input logic [5:0] keys);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) < 30)
			gap = $urandom_range(1, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		key_lines <= keys;
		do @(posedge clk); while (!in_ready);
		sb.note_input(k, keys);
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	// key samples mostly look like real keypads: repeats and single-key changes
	function automatic logic [5:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return sb.prev_keys;
		if (r < 6)
			return sb.prev_keys ^ (6'd1 << $urandom_range(0, 5));
		return 6'($urandom);
	endfunction

	function automatic logic [1:0] pick_kind(int mix);
		int r;
		int p_sample, p_read, p_clear;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:  begin p_sample = 85; p_read = 97; p_clear = 99; end
			MIX_DRAIN: begin p_sample = 20; p_read = 97; p_clear = 99; end
			default:   begin p_sample = 55; p_read = 93; p_clear = 98; end
		endcase
		if (r < p_sample)
			return KIND_SAMPLE;
		if (r < p_read)
			return KIND_READ;
		if (r < p_clear)
			return KIND_CLEAR;
		return KIND_UNUSED;
	endfunction

	// result side: checks every transfer and throttles out_ready
	initial begin
		int stall;
		int hold_left;
		stall     = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(empty_res, key_index, released);
			if (hold_left == 0 && long_hold_req) begin
				hold_left     = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 20) begin
				stall = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int mix;
		int chunk;
		logic [1:0] k;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty read, all keys pressed then read back in key order
		send_item(KIND_READ, 6'h3F);
		send_item(KIND_SAMPLE, 6'h3F);
		repeat (6) send_item(KIND_READ, 6'h00);
		send_item(KIND_READ, 6'h2A);
		// all released, then an unchanged sample that pushes nothing
		send_item(KIND_SAMPLE, 6'h00);
		send_item(KIND_SAMPLE, 6'h00);
		// overfill: one slot stays free, the rest of these events are dropped
		send_item(KIND_SAMPLE, 6'h2A);
		send_item(KIND_SAMPLE, 6'h15);
		repeat (3) send_item(KIND_READ, 6'h15);
		// clear empties the ring but keeps the last sample
		send_item(KIND_CLEAR, 6'h3F);
		send_item(KIND_READ, 6'h00);
		send_item(KIND_UNUSED, 6'h3F);
		send_item(KIND_SAMPLE, 6'h01);
		repeat (3) send_item(KIND_READ, 6'h3F);

		// random part in chunks of differing mix
		chunk = 0;
		while (items_sent < RANDOM_ITEMS + 25) begin
			mix     = $urandom_range(MIX_BALANCED, MIX_DRAIN);
			no_idle = (chunk == 5) || (items_sent > RANDOM_ITEMS + 25 - QUIET_ITEMS);
			// long receiver hold-off: reads pile up and the input stalls
			if (chunk == 3)
				long_hold_req = 1'b1;
			repeat (40) begin
				k = pick_kind(mix);
				send_item(k, (k == KIND_SAMPLE) ? pick_sample() : 6'($urandom));
			end
			chunk++;
		end
		in_valid <= 1'b0;

		while (sb.pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples, %0d reads (%0d empty), %0d clears",
			sb.samples, sb.reads, sb.empties, sb.clears);
		$display("events stored %0d, dropped on full ring %0d, results checked %0d",
			sb.pushes, sb.drops, sb.checked);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
